@@ rtl/gcd_pkg.sv @@
// Package: shared constants, arctangent table and payload types for the distance pipeline.
package gcd_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 34;
    localparam logic signed [CW-1:0] Q30_ONE   = 34'sd1073741824;
    localparam logic signed [CW-1:0] CORDIC_GN = 34'sd652032874;
    localparam logic [30:0] PIQ29 = 31'd1686629713;

    function automatic logic signed [CW-1:0] atan_unit(input int i);
        logic signed [CW-1:0] r;
        begin
            case (i)
                0: r = 34'sd536870912;
                1: r = 34'sd316933406;
                2: r = 34'sd167458908;
                3: r = 34'sd85004757;
                4: r = 34'sd42667331;
                5: r = 34'sd21354465;
                6: r = 34'sd10679838;
                7: r = 34'sd5340245;
                8: r = 34'sd2670163;
                9: r = 34'sd1335087;
                10: r = 34'sd667544;
                11: r = 34'sd333772;
                12: r = 34'sd166886;
                13: r = 34'sd83443;
                14: r = 34'sd41722;
                15: r = 34'sd20861;
                16: r = 34'sd10430;
                17: r = 34'sd5215;
                18: r = 34'sd2608;
                19: r = 34'sd1304;
                20: r = 34'sd652;
                21: r = 34'sd326;
                22: r = 34'sd163;
                23: r = 34'sd81;
                24: r = 34'sd41;
                25: r = 34'sd20;
                26: r = 34'sd10;
                27: r = 34'sd5;
                28: r = 34'sd3;
                29: r = 34'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

endpackage

@@ rtl/gcd_cordic.sv @@
// Pipelined CORDIC: rotation mode for cosines, vectoring mode for atan2.
module gcd_cordic
    import gcd_pkg::*;
#(
    parameter bit VECTORING = 1'b0,
    parameter int SIDE_W    = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  cordic_t           in_data,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output cordic_t           out_data,
    output logic [SIDE_W-1:0] out_side
);

    cordic_t           st_reg   [CORDIC_STEPS];
    logic [SIDE_W-1:0] side_reg [CORDIC_STEPS];
    logic              vld_reg  [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        cordic_t           cur;
        logic [SIDE_W-1:0] side_cur;
        logic              vld_cur;
        cordic_t           step_next;
        if (i == 0)
        begin : g_first
            assign cur      = in_data;
            assign side_cur = in_side;
            assign vld_cur  = in_valid;
        end
        else
        begin : g_next
            assign cur      = st_reg[i-1];
            assign side_cur = side_reg[i-1];
            assign vld_cur  = vld_reg[i-1];
        end
        always_comb
        begin
            logic signed [CW-1:0] xs;
            logic signed [CW-1:0] ys;
            logic                 up;
            xs = cur.x >>> i;
            ys = cur.y >>> i;
            up = VECTORING ? (cur.y > 0) : (cur.z >= 0);
            if (VECTORING ? up : up)
            begin
                step_next.x = VECTORING ? cur.x + ys : cur.x - ys;
                step_next.y = VECTORING ? cur.y - xs : cur.y + xs;
                step_next.z = VECTORING ? cur.z + atan_unit(i)
                                        : cur.z - atan_unit(i);
            end
            else
            begin
                step_next.x = VECTORING ? cur.x - ys : cur.x + ys;
                step_next.y = VECTORING ? cur.y + xs : cur.y - xs;
                step_next.z = VECTORING ? cur.z - atan_unit(i)
                                        : cur.z + atan_unit(i);
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_cur;
            end
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[i]   <= step_next;
                side_reg[i] <= side_cur;
            end
        end
    end

    assign out_valid = vld_reg[CORDIC_STEPS-1];
    assign out_data  = st_reg[CORDIC_STEPS-1];
    assign out_side  = side_reg[CORDIC_STEPS-1];

endmodule

@@ rtl/great_circle_distance_top.sv @@
// Top level: haversine great-circle distance, fully pipelined.
//
//  channel   | dir | handshake        | payload
//  s_axis    | in  | tvalid / tready  | tdata[113:0] lon1, lat1, lon2, lat2 (128 bits)
//  m_axis    | out | tvalid / tready  | tdata[25:0] distance (32 bits)
//  cfg       | in  | cfg_we           | cfg_data[15:0] sphere radius, km
//
//  One item per cycle unless the output stalls; there are two stages in front, 30 cosine
//  CORDIC stages, three for fold, product and clamp, 31 isqrt stages,
//  30 atan2 stages and three for the radius and pi multiplies and output.
//  Reset clears every valid bit and loads radius 6371.
//  A stall at the output freezes the whole pipeline: nothing is lost or
//  repeated; s_axis_tready follows m_axis_tready when the last stage is full.
module great_circle_distance_top
    import gcd_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 20,
    parameter int DIST_FRAC_BITS  = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // lon1[28:0] lat1[56:29] lon2[85:57] lat2[113:86]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [31:0]  m_axis_tdata    // distance[25:0]
);

    localparam logic [63:0] KDEG =
        64'(((65'd1 << (64 - ANGLE_FRAC_BITS)) + 65'd180) / 65'd360);
    localparam int SH = 59 - DIST_FRAC_BITS;

    logic [15:0] radius_reg;
    logic        en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= 16'd6371;
        else if (cfg_we)
            radius_reg <= cfg_data;
    end

    // The output register is the last stage; advance everything while it
    // is empty or being taken.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: latch angles and form differences exactly in degrees.
    logic        v1_reg;
    logic signed [29:0] a1_reg [4];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg[0] <= 30'(signed'(s_axis_tdata[56:29]));
            a1_reg[1] <= 30'(signed'(s_axis_tdata[113:86]));
            a1_reg[2] <= 30'(signed'(s_axis_tdata[113:86]))
                       - 30'(signed'(s_axis_tdata[56:29]));
            a1_reg[3] <= 30'(signed'(s_axis_tdata[85:57]))
                       - 30'(signed'(s_axis_tdata[28:0]));
        end
    end

    // Stage 2: degrees to angle units (one multiply each, wrap to 32 bits).
    logic        v2_reg;
    logic [31:0] u2_reg [4];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end
    for (genvar k = 0; k < 4; k++) begin : g_units
        logic [63:0] prod;
        assign prod = 64'(signed'(a1_reg[k])) * KDEG + 64'h8000_0000;
        always_ff @(posedge clk)
        begin
            if (en)
                u2_reg[k] <= prod[63:32];
        end
    end

    // Four cosine CORDICs; the quadrant rides along as side data.
    logic        cv [4];
    cordic_t     cd [4];
    logic [1:0]  cq [4];
    for (genvar k = 0; k < 4; k++) begin : g_cos
        cordic_t cin;
        assign cin.x = CORDIC_GN;
        assign cin.y = '0;
        assign cin.z = CW'({2'b00, u2_reg[k][29:0]});
        gcd_cordic #(.VECTORING(1'b0), .SIDE_W(2)) u_cos (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(v2_reg), .in_data(cin), .in_side(u2_reg[k][31:30]),
            .out_valid(cv[k]), .out_data(cd[k]), .out_side(cq[k])
        );
    end

    // Stage C: quadrant fold and clamp.
    logic        v3_reg;
    logic signed [CW-1:0] c3_reg [4];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= cv[0];
    end
    for (genvar k = 0; k < 4; k++) begin : g_fold
        logic signed [CW-1:0] r;
        always_comb
        begin
            case (cq[k])
                2'd0: r = cd[k].x;
                2'd1: r = -cd[k].y;
                2'd2: r = -cd[k].x;
                default: r = cd[k].y;
            endcase
        end
        always_ff @(posedge clk)
        begin
            if (en)
                c3_reg[k] <= (r > Q30_ONE) ? Q30_ONE : ((r < -Q30_ONE) ? -Q30_ONE : r);
        end
    end

    // Stage 4: c1*c2 and the two haversine halves.
    logic        v4_reg;
    logic signed [CW-1:0] p4_reg, hl4_reg, ho4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        logic signed [67:0] m;
        if (en)
        begin
            m       = 68'(c3_reg[0]) * 68'(c3_reg[1]);
            p4_reg  <= CW'(m >>> 30);
            hl4_reg <= (Q30_ONE - c3_reg[2]) >>> 1;
            ho4_reg <= (Q30_ONE - c3_reg[3]) >>> 1;
        end
    end

    // Stage 5: a = hlat + prod*hlon, clamped to [0, 1].
    logic        v5_reg;
    logic [30:0] a5_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        logic signed [67:0] m;
        logic signed [CW:0] s;
        if (en)
        begin
            m = 68'(p4_reg) * 68'(ho4_reg);
            s = (CW+1)'(hl4_reg) + (CW+1)'(m >>> 30);
            if (s < 0)
                a5_reg <= '0;
            else if (s > (CW+1)'(Q30_ONE))
                a5_reg <= 31'(Q30_ONE);
            else
                a5_reg <= 31'(s);
        end
    end

    // Square roots: one result bit per stage, two radicands in parallel.
    localparam int SQ = 31;
    logic        sqv_reg [SQ];
    logic [61:0] rem_reg [SQ][2];
    logic [61:0] rad_reg [SQ][2];
    logic [30:0] res_reg [SQ][2];
    logic [61:0] rad_first [2];
    assign rad_first[0] = {a5_reg, 31'd0} >> 1;
    assign rad_first[1] = {31'(Q30_ONE) - a5_reg, 31'd0} >> 1;
    for (genvar i = 0; i < SQ; i++) begin : g_sqrt
        logic v_in;
        if (i == 0)
        begin : g_first
            assign v_in = v5_reg;
        end
        else
        begin : g_next
            assign v_in = sqv_reg[i-1];
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sqv_reg[i] <= 1'b0;
            else if (en)
                sqv_reg[i] <= v_in;
        end
        for (genvar j = 0; j < 2; j++) begin : g_lane
            logic [61:0] rad_in, rem_in;
            logic [30:0] res_in;
            logic [63:0] r2, tr;
            if (i == 0)
            begin : g_first
                assign rad_in = rad_first[j];
                assign rem_in = '0;
                assign res_in = '0;
            end
            else
            begin : g_next
                assign rad_in = rad_reg[i-1][j];
                assign rem_in = rem_reg[i-1][j];
                assign res_in = res_reg[i-1][j];
            end
            assign r2 = {rem_in, rad_in[61:60]};
            assign tr = {31'd0, res_in, 2'b01};
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[i][j] <= rad_in << 2;
                    if (r2 >= tr)
                    begin
                        rem_reg[i][j] <= 62'(r2 - tr);
                        res_reg[i][j] <= {res_in[29:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i][j] <= r2[61:0];
                        res_reg[i][j] <= {res_in[29:0], 1'b0};
                    end
                end
            end
        end
    end

    // atan2(sa, sb) by vectoring CORDIC.
    logic    tv;
    cordic_t td;
    logic    unused_side;
    cordic_t vin;
    assign vin.x = CW'(res_reg[SQ-1][1]);
    assign vin.y = CW'(res_reg[SQ-1][0]);
    assign vin.z = '0;
    gcd_cordic #(.VECTORING(1'b1), .SIDE_W(1)) u_atan (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(sqv_reg[SQ-1]), .in_data(vin), .in_side(1'b0),
        .out_valid(tv), .out_data(td), .out_side(unused_side)
    );

    // Stage D1: theta clamp and radius * theta.
    logic        vd1_reg;
    logic [46:0] t_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd1_reg <= 1'b0;
        else if (en)
            vd1_reg <= tv;
    end
    always_ff @(posedge clk)
    begin
        logic [30:0] th;
        if (en)
        begin
            th = (td.z < 0) ? 31'd0 : ((td.z > Q30_ONE) ? 31'(Q30_ONE) : 31'(td.z));
            t_reg <= 47'(radius_reg) * 47'(th);
        end
    end

    // Stage D2: split multiply by pi.
    logic        vd2_reg;
    logic [63:0] hi_reg, lh_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vd2_reg <= 1'b0;
        else if (en)
            vd2_reg <= vd1_reg;
    end
    always_ff @(posedge clk)
    begin
        logic [63:0] lp;
        if (en)
        begin
            hi_reg <= 64'(t_reg[46:16]) * 64'(PIQ29);
            lp      = 64'(t_reg[15:0]) * 64'(PIQ29);
            lh_reg <= lp >> 16;
        end
    end

    // Output register: round and hold until taken.
    logic [25:0] dist_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (en)
            m_axis_tvalid <= vd2_reg;
    end
    always_ff @(posedge clk)
    begin
        logic [63:0] d;
        if (en)
        begin
            d = (hi_reg + lh_reg + (64'd1 << (SH - 17))) >> (SH - 16);
            dist_reg <= d[25:0];
        end
    end
    assign m_axis_tdata = {6'd0, dist_reg};

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");
    a_ready : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow output stage");
    a_radius : assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(radius_reg))
        else $error("radius changed without a write");

endmodule
